// File: src/smj_pkg.sv
// ----------------------------------------------------------------------------
// smj_pkg
// Shared types and constants for the sort-merge inner join stage.
// ----------------------------------------------------------------------------
package smj_pkg;

  localparam int KEY_W           = 64;
  localparam int ROW_W           = 32;
  localparam int DEF_GROUP_DEPTH = 8;
  localparam int DEF_ROW_BITS    = 32;

  localparam logic SIDE_LEFT  = 1'b0;
  localparam logic SIDE_RIGHT = 1'b1;

  // One joined pair on its way to the output register
  typedef struct packed {
    logic [ROW_W-1:0] left_row;
    logic [ROW_W-1:0] right_row;
    logic             group_overflow;
    logic             last_pair;
  } pair_t;

endpackage

// File: src/sort_merge_inner_join.sv
// ----------------------------------------------------------------------------
// sort_merge_inner_join
// Equi-join stage: gathers equal-key rows into left/right groups and emits
// their cross product, left-major, when the key changes or on the final item.
// ----------------------------------------------------------------------------
// Items are taken one at a time; item_stall stays high until the item is fully
// handled. An item that closes no group passes through capture, key check and
// group write. Closing a group emits each pair by reading both group RAMs and
// then loading the pair register, which waits while the sink holds
// pair_stall; a one-sided group closes with no read or load step. Each group
// side lives in a GROUP_DEPTH-entry RAM with one read port, which sets the
// pair rate. Rows beyond GROUP_DEPTH on a side are dropped and every pair of
// that group carries group_overflow. Only the low ROW_BITS bits of row_index
// are kept.
module sort_merge_inner_join
  import smj_pkg::*;
#(
  parameter int GROUP_DEPTH = DEF_GROUP_DEPTH,
  parameter int ROW_BITS    = DEF_ROW_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  logic             side,
  input  logic [KEY_W-1:0] join_key,
  input  logic [ROW_W-1:0] row_index,
  input  logic             final_item,
  output logic             pair_valid,
  input  logic             pair_stall,
  output logic [ROW_W-1:0] left_row,
  output logic [ROW_W-1:0] right_row,
  output logic             group_overflow,
  output logic             last_pair
);

  localparam int RW = (ROW_BITS < ROW_W) ? ROW_BITS : ROW_W;
  localparam int IW = (GROUP_DEPTH > 1) ? $clog2(GROUP_DEPTH) : 1;
  localparam int CW = $clog2(GROUP_DEPTH + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_ADD   = 3'd2;
  localparam logic [2:0] S_RD    = 3'd3;
  localparam logic [2:0] S_LD    = 3'd4;

  logic [2:0]       state;
  logic             h_side;
  logic [KEY_W-1:0] h_key;
  logic [RW-1:0]    h_row;
  logic             h_fin;

  logic [KEY_W-1:0] group_key;
  logic             group_open;
  logic [CW-1:0]    left_cnt;
  logic [CW-1:0]    right_cnt;
  logic             ovf_seen;
  logic             flush_fin;
  logic [IW-1:0]    i_idx;
  logic [IW-1:0]    j_idx;

  logic [CW-1:0] lc_eff, rc_eff, lc_add, rc_add;
  logic          l_room, r_room, l_we, r_we, side_full;
  logic          rd_en, pair_free, pair_load, pair_last, j_wrap;
  logic [RW-1:0] l_rdata, r_rdata;
  pair_t         pair_next;

  assign item_stall = (state != S_IDLE);

  // group state as seen by the row being added
  assign lc_eff    = group_open ? left_cnt : '0;
  assign rc_eff    = group_open ? right_cnt : '0;
  assign l_room    = lc_eff < CW'(GROUP_DEPTH);
  assign r_room    = rc_eff < CW'(GROUP_DEPTH);
  assign l_we      = (state == S_ADD) && (h_side == SIDE_LEFT) && l_room;
  assign r_we      = (state == S_ADD) && (h_side == SIDE_RIGHT) && r_room;
  assign side_full = (h_side == SIDE_LEFT) ? !l_room : !r_room;
  assign lc_add    = lc_eff + CW'(l_we);
  assign rc_add    = rc_eff + CW'(r_we);

  assign rd_en     = (state == S_RD);
  assign j_wrap    = CW'(j_idx) == CW'(right_cnt - 1'b1);
  assign pair_last = j_wrap && (CW'(i_idx) == CW'(left_cnt - 1'b1));
  assign pair_load = (state == S_LD) && pair_free;

  always_comb begin
    pair_next.left_row       = ROW_W'(l_rdata);
    pair_next.right_row      = ROW_W'(r_rdata);
    pair_next.group_overflow = ovf_seen;
    pair_next.last_pair      = pair_last;
  end

  smj_ram #(.WIDTH(RW), .DEPTH(GROUP_DEPTH)) u_left_ram (
    .clk   (clk),
    .we    (l_we),
    .waddr (lc_eff[IW-1:0]),
    .wdata (h_row),
    .re    (rd_en),
    .raddr (i_idx),
    .rdata (l_rdata)
  );

  smj_ram #(.WIDTH(RW), .DEPTH(GROUP_DEPTH)) u_right_ram (
    .clk   (clk),
    .we    (r_we),
    .waddr (rc_eff[IW-1:0]),
    .wdata (h_row),
    .re    (rd_en),
    .raddr (j_idx),
    .rdata (r_rdata)
  );

  smj_pair_out u_pair_out (
    .clk            (clk),
    .rst            (rst),
    .load           (pair_load),
    .pair_in        (pair_next),
    .free           (pair_free),
    .pair_valid     (pair_valid),
    .pair_stall     (pair_stall),
    .left_row       (left_row),
    .right_row      (right_row),
    .group_overflow (group_overflow),
    .last_pair      (last_pair)
  );

  // item capture
  always_ff @(posedge clk) begin
    if (state == S_IDLE && item_valid) begin
      h_side <= side;
      h_key  <= join_key;
      h_row  <= row_index[RW-1:0];
      h_fin  <= final_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      group_key  <= '0;
      group_open <= 1'b0;
      left_cnt   <= '0;
      right_cnt  <= '0;
      ovf_seen   <= 1'b0;
      flush_fin  <= 1'b0;
      i_idx      <= '0;
      j_idx      <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (group_open && h_key != group_key) begin
            if (left_cnt != '0 && right_cnt != '0) begin
              flush_fin <= 1'b0;
              i_idx     <= '0;
              j_idx     <= '0;
              state     <= S_RD;
            end else begin
              // one-sided group closes silently
              group_open <= 1'b0;
              left_cnt   <= '0;
              right_cnt  <= '0;
              ovf_seen   <= 1'b0;
              state      <= S_ADD;
            end
          end else begin
            state <= S_ADD;
          end
        end
        S_ADD: begin
          if (!group_open) begin
            group_key <= h_key;
          end
          if (h_fin) begin
            if (lc_add != '0 && rc_add != '0) begin
              group_open <= 1'b1;
              left_cnt   <= lc_add;
              right_cnt  <= rc_add;
              ovf_seen   <= (group_open && ovf_seen) || side_full;
              flush_fin  <= 1'b1;
              i_idx      <= '0;
              j_idx      <= '0;
              state      <= S_RD;
            end else begin
              group_open <= 1'b0;
              left_cnt   <= '0;
              right_cnt  <= '0;
              ovf_seen   <= 1'b0;
              state      <= S_IDLE;
            end
          end else begin
            group_open <= 1'b1;
            left_cnt   <= lc_add;
            right_cnt  <= rc_add;
            ovf_seen   <= (group_open && ovf_seen) || side_full;
            state      <= S_IDLE;
          end
        end
        S_RD: begin
          state <= S_LD;
        end
        S_LD: begin
          if (pair_free) begin
            if (pair_last) begin
              group_open <= 1'b0;
              left_cnt   <= '0;
              right_cnt  <= '0;
              ovf_seen   <= 1'b0;
              state      <= flush_fin ? S_IDLE : S_ADD;
            end else begin
              if (j_wrap) begin
                j_idx <= '0;
                i_idx <= i_idx + 1'b1;
              end else begin
                j_idx <= j_idx + 1'b1;
              end
              state <= S_RD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: src/smj_ram.sv
// ----------------------------------------------------------------------------
// smj_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module smj_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/smj_pair_out.sv
// ----------------------------------------------------------------------------
// smj_pair_out
// Output register for joined pairs; decouples the sequencer from the sink.
// ----------------------------------------------------------------------------
module smj_pair_out
  import smj_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  pair_t            pair_in,
  output logic             free,
  output logic             pair_valid,
  input  logic             pair_stall,
  output logic [ROW_W-1:0] left_row,
  output logic [ROW_W-1:0] right_row,
  output logic             group_overflow,
  output logic             last_pair
);

  pair_t pair;

  // register can take a new pair when empty or being drained this cycle
  assign free = !pair_valid || !pair_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_valid <= 1'b0;
    end else if (free) begin
      pair_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      pair <= pair_in;
    end
  end

  assign left_row       = pair.left_row;
  assign right_row      = pair.right_row;
  assign group_overflow = pair.group_overflow;
  assign last_pair      = pair.last_pair;

endmodule

// File: src/smj_check.sv
// ----------------------------------------------------------------------------
// smj_check
// Port-level checks for sort_merge_inner_join, bound to the top level.
// ----------------------------------------------------------------------------
module smj_check
  import smj_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             item_valid,
  input logic             item_stall,
  input logic             pair_valid,
  input logic             pair_stall,
  input logic [ROW_W-1:0] left_row,
  input logic [ROW_W-1:0] right_row,
  input logic             group_overflow,
  input logic             last_pair
);

  // no pair comes out of reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !pair_valid)
    else $error("pair_valid high after reset");

  // an accepted item always makes the block busy in the next cycle
  a_busy_after_item: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> item_stall)
    else $error("item taken back to back");

  // while pairs of a group remain, no new item may be taken
  a_busy_mid_group: assert property (@(posedge clk) disable iff (rst)
    (pair_valid && !pair_stall && !last_pair) |-> item_stall)
    else $error("item taken while a group is still emitting");

  // a stalled pair holds
  a_pair_hold: assert property (@(posedge clk) disable iff (rst)
    (pair_valid && pair_stall) |=>
      (pair_valid && $stable(left_row) && $stable(right_row) &&
       $stable(group_overflow) && $stable(last_pair)))
    else $error("stalled pair changed");

endmodule

bind sort_merge_inner_join smj_check u_smj_check (
  .clk            (clk),
  .rst            (rst),
  .item_valid     (item_valid),
  .item_stall     (item_stall),
  .pair_valid     (pair_valid),
  .pair_stall     (pair_stall),
  .left_row       (left_row),
  .right_row      (right_row),
  .group_overflow (group_overflow),
  .last_pair      (last_pair)
);

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for sort_merge_inner_join. Feeds keyed rows from both
// tables, mirrors the grouping and cross-product pairing in a scoreboard,
// and checks every emitted pair in order under random idling and stalls.
// ----------------------------------------------------------------------------
module tb;
  import smj_pkg::*;

  localparam int GROUP_DEPTH    = DEF_GROUP_DEPTH;
  localparam int RANDOM_ITEMS   = 150;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 150;

  // Mirrors the group buffers; queues the pairs each accepted item releases
  class pair_scoreboard;
    logic [KEY_W-1:0] cur_key;
    bit               grp_open;
    logic [ROW_W-1:0] left_rows[GROUP_DEPTH];
    logic [ROW_W-1:0] right_rows[GROUP_DEPTH];
    int               left_cnt;
    int               right_cnt;
    bit               dropped;
    pair_t            pending_pairs[$];
    int               errors;

    function new();
      cur_key   = '0;
      grp_open  = 0;
      left_cnt  = 0;
      right_cnt = 0;
      dropped   = 0;
      errors    = 0;
    endfunction

    function void close_group();
      for (int i = 0; i < left_cnt; i++)
        for (int j = 0; j < right_cnt; j++)
          pending_pairs.insert(pending_pairs.size(),
                               pair_t'{left_rows[i], right_rows[j], dropped, 1'b0});
      grp_open  = 0;
      left_cnt  = 0;
      right_cnt = 0;
      dropped   = 0;
    endfunction

    function void note_item(logic s, logic [KEY_W-1:0] k, logic [ROW_W-1:0] r, logic f);
      int start;
      start = pending_pairs.size();
      if (grp_open && k != cur_key) close_group();
      if (!grp_open) begin
        grp_open  = 1;
        cur_key   = k;
        left_cnt  = 0;
        right_cnt = 0;
        dropped   = 0;
      end
      if (s == SIDE_LEFT) begin
        if (left_cnt < GROUP_DEPTH) begin
          left_rows[left_cnt] = r;
          left_cnt++;
        end else begin
          dropped = 1;
        end
      end else begin
        if (right_cnt < GROUP_DEPTH) begin
          right_rows[right_cnt] = r;
          right_cnt++;
        end else begin
          dropped = 1;
        end
      end
      if (f) close_group();
      if (pending_pairs.size() > start)
        pending_pairs[pending_pairs.size()-1].last_pair = 1'b1;
    endfunction

    function void check_pair(pair_t got);
      pair_t want;
      if (pending_pairs.size() == 0) begin
        $error("unexpected pair: left_row=%h right_row=%h", got.left_row, got.right_row);
        errors++;
        return;
      end
      want = pending_pairs.pop_front();
      if (got.left_row !== want.left_row) begin
        $error("left_row: expected %h, actual %h", want.left_row, got.left_row);
        errors++;
      end
      if (got.right_row !== want.right_row) begin
        $error("right_row: expected %h, actual %h", want.right_row, got.right_row);
        errors++;
      end
      if (got.group_overflow !== want.group_overflow) begin
        $error("group_overflow: expected %b, actual %b", want.group_overflow,
               got.group_overflow);
        errors++;
      end
      if (got.last_pair !== want.last_pair) begin
        $error("last_pair: expected %b, actual %b", want.last_pair, got.last_pair);
        errors++;
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             item_valid = 1'b0;
  logic             item_stall;
  logic             side = SIDE_LEFT;
  logic [KEY_W-1:0] join_key = '0;
  logic [ROW_W-1:0] row_index = '0;
  logic             final_item = 1'b0;
  logic             pair_valid;
  logic             pair_stall = 1'b0;
  logic [ROW_W-1:0] left_row;
  logic [ROW_W-1:0] right_row;
  logic             group_overflow;
  logic             last_pair;

  pair_scoreboard sb;
  int items_sent = 0;
  int random_sent = 0;
  bit quiet = 0;
  int idle_cycles = 0;

  sort_merge_inner_join i_dut (.*);

  always #10 clk = ~clk;

  // idling on, except in every third stretch of 25 items and at the tail
  function automatic bit idle_on();
    return !quiet && ((items_sent / 25) % 3 != 1);
  endfunction

  task automatic send_item(input logic s, input logic [KEY_W-1:0] k,
                           input logic [ROW_W-1:0] r, input logic f);
    if (idle_on() && $urandom_range(0, 3) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    item_valid <= 1'b1;
    side       <= s;
    join_key   <= k;
    row_index  <= r;
    final_item <= f;
    do @(posedge clk); while (item_stall);
    sb.note_item(s, k, r, f);
    items_sent++;
  endtask

  // one key group with sides interleaved at random
  task automatic send_group(input logic [KEY_W-1:0] k, input int n_left, input int n_right,
                            input bit fin_last);
    int  rl;
    int  rr;
    logic s;
    logic f;
    rl = n_left;
    rr = n_right;
    while (rl + rr > 0) begin
      if (rl == 0) s = SIDE_RIGHT;
      else if (rr == 0) s = SIDE_LEFT;
      else s = 1'($urandom_range(0, 1));
      if (s == SIDE_LEFT) rl--;
      else rr--;
      f = (rl + rr == 0) ? fin_last : ($urandom_range(0, 19) == 0);
      send_item(s, k, $urandom, f);
      random_sent++;
    end
  endtask

  // receiver: one long hold-off to fill the block, random stall bursts otherwise
  initial begin
    int  stall_left;
    bit  held_off;
    stall_left = 0;
    held_off   = 0;
    wait (rst == 1'b0);
    forever begin
      @(posedge clk);
      if (!held_off && items_sent >= 80) begin
        held_off = 1;
        pair_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        pair_stall <= 1'b0;
      end else if (stall_left > 0) begin
        pair_stall <= 1'b1;
        stall_left--;
      end else if (idle_on() && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 10) - 1;
        pair_stall <= 1'b1;
      end else begin
        pair_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && pair_valid && !pair_stall)
      sb.check_pair({left_row, right_row, group_overflow, last_pair});
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (pair_valid && !pair_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    logic [KEY_W-1:0] key;
    int               n_left;
    int               n_right;
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed part
    send_item(SIDE_LEFT, '0, '0, 1'b0);
    send_item(SIDE_RIGHT, '0, '1, 1'b0);
    send_item(SIDE_LEFT, '1, '1, 1'b0);              // closes a 1x1 group
    send_item(SIDE_LEFT, '1, 32'h0000_0005, 1'b0);   // left-only group
    send_item(SIDE_RIGHT, 64'h1, 32'hA5A5_5A5A, 1'b0); // key drops: nothing from left-only
    for (int i = 0; i < GROUP_DEPTH + 1; i++)        // one left row too many
      send_item(SIDE_LEFT, 64'h1, 32'h100 + i, 1'b0);
    send_item(SIDE_RIGHT, 64'h2, 32'h1234, 1'b1);    // key change on final
    send_item(SIDE_LEFT, 64'h3, 32'h5555_AAAA, 1'b0);
    send_item(SIDE_RIGHT, 64'h3, 32'hAAAA_5555, 1'b0);
    send_item(SIDE_RIGHT, 64'h3, 32'h8000_0001, 1'b1); // final within the group
    send_item(SIDE_RIGHT, 64'h4, 32'h7, 1'b1);       // lone final row

    // random part: mostly ascending keys, a full 8x8 group first
    key = {$urandom, $urandom};
    send_group(key, GROUP_DEPTH, GROUP_DEPTH, 1'b0);
    while (random_sent < RANDOM_ITEMS) begin
      if (random_sent >= RANDOM_ITEMS - 30) quiet = 1;
      if ($urandom_range(0, 6) == 0) key = {$urandom, $urandom};
      else key = key + $urandom_range(1, 1000);
      if ($urandom_range(0, 7) == 0) begin
        n_left  = $urandom_range(0, GROUP_DEPTH + 2);
        n_right = $urandom_range(0, GROUP_DEPTH + 2);
      end else begin
        n_left  = $urandom_range(0, 3);
        n_right = $urandom_range(0, 3);
      end
      if (n_left + n_right == 0) n_left = 1;
      send_group(key, n_left, n_right, $urandom_range(0, 7) == 0);
    end
    // flush whatever group is still open
    send_item(SIDE_RIGHT, key + 1, $urandom, 1'b1);
    item_valid <= 1'b0;

    while (sb.pending_pairs.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
